FILE: rtl/rsee_pkg.sv
// Shared types, constants and GF(256) helpers for the erasure parity encoder.
// Depends on nothing; the encoder unit, rsee_lane and rsee_drain refer to it by scoped names.
package rsee_pkg;

   // Default number of parity lanes built into the block.
   localparam int MAX_PARITY_DEF = 16;

   // Low byte of the field polynomial x^8+x^4+x^3+x^2+1.
   localparam logic [7:0] GF_REDUCE = 8'h1d;
   localparam logic [7:0] GF_ALPHA  = 8'h02;
   localparam logic [7:0] GF_ONE    = 8'h01;

   // Configuration reset values.
   localparam logic [7:0] DATA_COUNT_RST   = 8'd4;
   localparam logic [4:0] PARITY_COUNT_RST = 5'd2;

   // Configuration register indexes.
   localparam logic CSR_DATA_COUNT   = 1'b0;
   localparam logic CSR_PARITY_COUNT = 1'b1;

   // Per-byte control broadcast to all parity lanes.
   typedef struct packed {
      logic       step;   // a byte advances into the lanes this cycle
      logic       close;  // this byte is the last one of its column
      logic [7:0] data;   // the byte itself
   } lane_ctrl_type;

   // GF(256) multiply, shift-and-add over the eight bits of b.
   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] x;
      logic [7:0] r;
      x = a;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            r = r ^ x;
         end
         x = x[7] ? ({x[6:0], 1'b0} ^ GF_REDUCE) : {x[6:0], 1'b0};
      end
      return r;
   endfunction

   // alpha^n, evaluated at elaboration for the per-lane step coefficient.
   function automatic logic [7:0] gf_alpha_pow(input int n);
      logic [7:0] v;
      v = GF_ONE;
      for (int i = 0; i < n; i++) begin
         v = gf_mul(v, GF_ALPHA);
      end
      return v;
   endfunction

endpackage

FILE: rtl/rsee_req_if.sv
// Request channel of the erasure parity encoder: one data byte per transfer.
// Depends on nothing.
interface rsee_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

FILE: rtl/rsee_rsp_if.sv
// Result channel of the erasure parity encoder: one parity byte per transfer.
// Depends on nothing.
interface rsee_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] parity_byte;
   logic [3:0] parity_row;
   logic       last_parity;

   modport source (output valid, output parity_byte, output parity_row,
                   output last_parity, input ready);
   modport sink (input valid, input parity_byte, input parity_row,
                 input last_parity, output ready);
endinterface

FILE: rtl/rs_erasure_parity_encoder_unit.sv
// Reed-Solomon erasure parity encoder, GF(256) with polynomial 0x11d, Vandermonde rows.
// Depends on rsee_pkg, rsee_req_if, rsee_rsp_if, rsee_lane and rsee_drain.
//
// Usage: data bytes enter on req_bus, column by column, one byte per source in
// source order; data_count bytes make a column. After a column's last byte the
// block sends one parity byte per active parity row on rsp_bus, rows in order,
// with parity_row and last_parity marking the final row of the column.
// csr_we writes data_count (index 0) or parity_count (index 1) from csr_wdata;
// write only while no request or result is in flight.
// Throughput: one byte per cycle. All parity lanes update in parallel from the
// input register, and a finished column moves into shadow registers that drain
// one row per cycle while the receiver takes them, as the next column accumulates.
// The closing byte of a column waits in the input register while the previous
// burst is still draining. After a close, the column moves from the input register
// into the shadow registers and its first parity byte then into the output register;
// the rest follow one per cycle while the receiver takes them.
// Reset clears the accumulators, powers, column position and both channels and
// restores data_count = 4, parity_count = 2. When the receiver stalls, the
// output register holds its byte, the burst pauses, and requests keep being
// accepted until a further column close finds the shadow registers still full.
module rs_erasure_parity_encoder_unit #(
   parameter int MAX_PARITY = rsee_pkg::MAX_PARITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   rsee_req_if.sink    req_bus,
   rsee_rsp_if.source  rsp_bus,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int CNT_W = $clog2(MAX_PARITY + 1);

   logic [7:0]                  data_count_ff;
   logic [7:0]                  data_count_in;
   logic [4:0]                  parity_count_ff;
   logic [4:0]                  parity_count_in;
   logic                        in_valid_ff;
   logic                        in_valid_in;
   logic [7:0]                  in_data_ff;
   logic [7:0]                  in_data_in;
   logic [7:0]                  source_pos_ff;
   logic [7:0]                  source_pos_in;
   logic [CNT_W-1:0]            rows_active;
   logic [7:0]                  need;
   logic [8:0]                  pos_plus;
   logic                        closes;
   logic                        advance;
   logic                        load;
   logic                        drain_busy;
   logic                        req_take;
   logic [MAX_PARITY-1:0]       lane_en;
   logic [MAX_PARITY-1:0][7:0]  acc_bus;
   rsee_pkg::lane_ctrl_type     lane_ctrl;

   // Configuration registers.
   always_comb begin
      data_count_in   = data_count_ff;
      parity_count_in = parity_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            rsee_pkg::CSR_DATA_COUNT:   data_count_in   = csr_wdata;
            rsee_pkg::CSR_PARITY_COUNT: parity_count_in = csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // Active rows: zero counts as one, saturated to the lanes built.
   always_comb begin
      int rows_int;
      rows_int = int'(parity_count_ff);
      if (rows_int == 0) begin
         rows_int = 1;
      end
      if (rows_int > MAX_PARITY) begin
         rows_int = MAX_PARITY;
      end
      rows_active = CNT_W'(rows_int);
   end

   // Column position; zero data count closes a column on every byte.
   assign need     = (data_count_ff == 8'd0) ? 8'd1 : data_count_ff;
   assign pos_plus = {1'b0, source_pos_ff} + 9'd1;
   assign closes   = (pos_plus >= {1'b0, need});

   // A closing byte needs the shadow registers free; other bytes always move.
   assign advance = in_valid_ff && (!closes || !drain_busy);
   assign load    = advance && closes;

   // Input register.
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in   = in_valid_ff && !advance;
      in_data_in    = in_data_ff;
      source_pos_in = source_pos_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_bus.data_byte;
      end
      if (advance) begin
         source_pos_in = closes ? 8'd0 : pos_plus[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_count_ff   <= rsee_pkg::DATA_COUNT_RST;
         parity_count_ff <= rsee_pkg::PARITY_COUNT_RST;
         in_valid_ff     <= 1'b0;
         source_pos_ff   <= '0;
      end else begin
         data_count_ff   <= data_count_in;
         parity_count_ff <= parity_count_in;
         in_valid_ff     <= in_valid_in;
         source_pos_ff   <= source_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
   end

   // Parity lanes, one per row, all fed the same byte.
   assign lane_ctrl.step  = advance;
   assign lane_ctrl.close = closes;
   assign lane_ctrl.data  = in_data_ff;

   for (genvar g = 0; g < MAX_PARITY; g++) begin : g_lane
      assign lane_en[g] = (CNT_W'(g) < rows_active);

      rsee_lane #(
         .ROW (g)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (lane_ctrl),
         .en       (lane_en[g]),
         .acc_next (acc_bus[g])
      );
   end

   // Burst drain toward the result channel.
   rsee_drain #(
      .MAX_PARITY (MAX_PARITY),
      .CNT_W      (CNT_W)
   ) u_drain (
      .clock   (clock),
      .reset   (reset),
      .load    (load),
      .rows    (rows_active),
      .acc_bus (acc_bus),
      .rsp_bus (rsp_bus),
      .busy    (drain_busy)
   );

`ifndef SYNTHESIS
   // A column close always starts a burst.
   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      load |=> drain_busy)
      else $error("column closed but drain not busy");

   // A column close restarts the column position.
   a_load_pos: assert property (@(posedge clock) disable iff (reset)
      load |=> (source_pos_ff == 8'd0))
      else $error("column position not cleared after close");

   // A byte held back in the input register is kept unchanged.
   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("held request byte lost or changed");
`endif

endmodule

FILE: rtl/rsee_lane.sv
// One parity row: accumulator and running coefficient power for row ROW.
// Depends on rsee_pkg for the GF(256) multiply and the lane control struct.
module rsee_lane #(
   parameter int ROW = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rsee_pkg::lane_ctrl_type ctrl,
   input  logic                   en,
   output logic [7:0]             acc_next
);

   // Coefficient step of this row, alpha^ROW.
   localparam logic [7:0] STEP_COEF = rsee_pkg::gf_alpha_pow(ROW);

   logic [7:0] acc_ff;
   logic [7:0] acc_in;
   logic [7:0] pow_ff;
   logic [7:0] pow_in;
   logic [7:0] acc_sum;
   logic [7:0] pow_step;

   // Product of the byte with the current power, and the next power.
   assign acc_sum  = acc_ff ^ rsee_pkg::gf_mul(ctrl.data, pow_ff);
   assign pow_step = rsee_pkg::gf_mul(pow_ff, STEP_COEF);

   // Value the row holds once this byte is in; captured at a column close.
   assign acc_next = en ? acc_sum : acc_ff;

   // Accumulate while enabled; every row clears when a column closes.
   always_comb begin
      acc_in = acc_ff;
      pow_in = pow_ff;
      if (ctrl.step) begin
         if (ctrl.close) begin
            acc_in = '0;
            pow_in = rsee_pkg::GF_ONE;
         end else if (en) begin
            acc_in = acc_sum;
            pow_in = pow_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         pow_ff <= rsee_pkg::GF_ONE;
      end else begin
         acc_ff <= acc_in;
         pow_ff <= pow_in;
      end
   end

endmodule

FILE: rtl/rsee_drain.sv
// Shadow registers and output register that send a finished column's parity bytes.
// Depends on rsee_pkg and the rsee_rsp_if result channel.
module rsee_drain #(
   parameter int MAX_PARITY = rsee_pkg::MAX_PARITY_DEF,
   parameter int CNT_W      = $clog2(MAX_PARITY + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  logic [CNT_W-1:0]                 rows,
   input  logic [MAX_PARITY-1:0][7:0]       acc_bus,
   rsee_rsp_if.source                       rsp_bus,
   output logic                             busy
);

   logic [7:0]       shadow_ff [MAX_PARITY];
   logic [7:0]       shadow_in [MAX_PARITY];
   logic [CNT_W-1:0] left_ff;
   logic [CNT_W-1:0] left_in;
   logic [3:0]       row_cnt_ff;
   logic [3:0]       row_cnt_in;
   logic             busy_ff;
   logic             busy_in;
   logic             out_valid_ff;
   logic             out_valid_in;
   logic [7:0]       out_byte_ff;
   logic [7:0]       out_byte_in;
   logic [3:0]       out_row_ff;
   logic [3:0]       out_row_in;
   logic             out_last_ff;
   logic             out_last_in;
   logic             issue;
   logic             final_row;

   // Move the next row into the output register when it is free or being taken.
   assign issue     = busy_ff && (!out_valid_ff || rsp_bus.ready);
   assign final_row = (left_ff == CNT_W'(1));

   // Shadow shift line: loaded at a column close with row 0 at the head, shifted down as each row issues.
   always_comb begin
      for (int i = 0; i < MAX_PARITY; i++) begin
         shadow_in[i] = shadow_ff[i];
      end
      if (load) begin
         for (int i = 0; i < MAX_PARITY; i++) begin
            shadow_in[i] = acc_bus[i];
         end
      end else if (issue) begin
         for (int i = 0; i < MAX_PARITY - 1; i++) begin
            shadow_in[i] = shadow_ff[i + 1];
         end
      end
   end

   // Burst bookkeeping: rows left, row index and busy flag.
   always_comb begin
      left_in    = left_ff;
      row_cnt_in = row_cnt_ff;
      busy_in    = busy_ff;
      if (load) begin
         left_in    = rows;
         row_cnt_in = '0;
         busy_in    = 1'b1;
      end else if (issue) begin
         left_in    = left_ff - CNT_W'(1);
         row_cnt_in = row_cnt_ff + 4'd1;
         busy_in    = !final_row;
      end
   end

   // Output register.
   always_comb begin
      out_byte_in  = out_byte_ff;
      out_row_in   = out_row_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      if (issue) begin
         out_valid_in = 1'b1;
         out_byte_in  = shadow_ff[0];
         out_row_in   = row_cnt_ff;
         out_last_in  = final_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         left_ff      <= '0;
         row_cnt_ff   <= '0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         left_ff      <= left_in;
         row_cnt_ff   <= row_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_PARITY; i++) begin
         shadow_ff[i] <= shadow_in[i];
      end
      out_byte_ff <= out_byte_in;
      out_row_ff  <= out_row_in;
      out_last_ff <= out_last_in;
   end

   assign busy                = busy_ff;
   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.parity_byte = out_byte_ff;
   assign rsp_bus.parity_row  = out_row_ff;
   assign rsp_bus.last_parity = out_last_ff;

`ifndef SYNTHESIS
   // Sending the final row of a burst frees the shadow registers.
   a_burst_ends: assert property (@(posedge clock) disable iff (reset)
      (issue && final_row) |=> !busy_ff)
      else $error("drain still busy after final row was sent");
`endif

endmodule
